// ===== sv/u128alu_pkg.sv =====
package u128alu_pkg;

   localparam int unsigned WordWidth = 128;
   localparam int unsigned HalfWidth = 64;

   typedef enum logic [2:0] {
      ACT_ADD    = 3'd0,
      ACT_SUB    = 3'd1,
      ACT_MUL    = 3'd2,
      ACT_SHL    = 3'd3,
      ACT_SHR    = 3'd4,
      ACT_DIVMOD = 3'd5,
      ACT_SETBIT = 3'd6,
      ACT_GETBIT = 3'd7
   } action_type;

   // Everything one word carries down the row of cells.
   typedef struct packed {
      action_type        action;
      logic [127:0]      a;
      logic [127:0]      b;
      logic [127:0]      acc;    // quotient or plain result
      logic [127:0]      rem;    // partial remainder, mul product
      logic              less_than;
      logic              equal;
      logic              bit_value;
      logic              divide_by_zero;
   } lane_type;

endpackage

// ===== sv/uint128_alu_with_divide_unit.sv =====
// Unsigned 128-bit arithmetic unit.
// The req_ channel takes one word per cycle while req_tready is high: action,
// operand A, operand B, shift count and bit index. The rsp_ channel returns one
// word per request, in order: result (quotient for divmod), remainder and four
// flags. The datapath is a row of 128 identical cells, one per bit position,
// each doing one restoring-division step or one shift-and-add multiply step.
// Every request, whatever its action, passes the front register, all cells
// and the output register; throughput is one word per cycle while nothing holds.
// The pipeline moves as a whole: when rsp_tvalid is high and rsp_tready is
// low, every stage holds and req_tready drops, so nothing is lost. An empty
// output register lets the pipe advance regardless of rsp_tready.
// Synchronous reset empties the pipeline; no results are pending after it.
// Remainder fields are zero except for divmod; a zero divisor gives zero
// quotient and remainder with divide_by_zero set.
module uint128_alu_with_divide_unit
   import u128alu_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // action[2:0], a_hi[66:3], a_lo[130:67], b_hi[194:131], b_lo[258:195],
   // shift_amount[266:259], bit_index[273:267], zero pad to 280
   input  logic [279:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // result_hi[63:0], result_lo[127:64], rem_hi[191:128], rem_lo[255:192],
   // less_than[256], equal[257], bit_value[258], divide_by_zero[259], pad to 264
   output logic [263:0] rsp_tdata
);

   logic     advance;
   logic     valid_chain [0:WordWidth];
   lane_type lane_chain  [0:WordWidth];
   logic     rsp_valid_ff;
   logic [263:0] rsp_data_ff, rsp_data_in;
   lane_type last;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance && !reset;

   u128alu_front u_front (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .in_valid     (req_tvalid),
      .action       (req_tdata[2:0]),
      .a            ({req_tdata[66:3], req_tdata[130:67]}),
      .b            ({req_tdata[194:131], req_tdata[258:195]}),
      .shift_amount (req_tdata[266:259]),
      .bit_index    (req_tdata[273:267]),
      .out_valid    (valid_chain[0]),
      .out_lane     (lane_chain[0])
   );

   for (genvar i = 0; i < WordWidth; i++) begin : g_cell
      u128alu_cell #(.BitPos(WordWidth - 1 - i)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (valid_chain[i]),
         .in_lane   (lane_chain[i]),
         .out_valid (valid_chain[i+1]),
         .out_lane  (lane_chain[i+1])
      );
   end

   always_comb begin
      last        = lane_chain[WordWidth];
      rsp_data_in = '0;
      rsp_data_in[259:256] = {last.divide_by_zero, last.bit_value, last.equal,
                              last.less_than};
      case (last.action)
         ACT_MUL: begin
            rsp_data_in[63:0]   = last.rem[127:64];
            rsp_data_in[127:64] = last.rem[63:0];
         end
         ACT_DIVMOD: begin
            if (!last.divide_by_zero) begin
               rsp_data_in[63:0]    = last.acc[127:64];
               rsp_data_in[127:64]  = last.acc[63:0];
               rsp_data_in[191:128] = last.rem[127:64];
               rsp_data_in[255:192] = last.rem[63:0];
            end
         end
         default: begin
            rsp_data_in[63:0]   = last.acc[127:64];
            rsp_data_in[127:64] = last.acc[63:0];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= valid_chain[WordWidth];
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== sv/u128alu_front.sv =====
module u128alu_front
   import u128alu_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  logic         in_valid,
   input  logic [2:0]   action,
   input  logic [127:0] a,
   input  logic [127:0] b,
   input  logic [7:0]   shift_amount,
   input  logic [6:0]   bit_index,
   output logic         out_valid,
   output lane_type     out_lane
);

   logic     valid_ff, valid_in;
   lane_type lane_ff, lane_in;
   logic [127:0] onehot;

   always_comb begin
      onehot          = 128'd1 << bit_index;
      lane_in         = '0;
      lane_in.action  = action_type'(action);
      lane_in.a       = a;
      lane_in.b       = b;
      lane_in.less_than = (a < b);
      lane_in.equal     = (a == b);
      case (action_type'(action))
         ACT_ADD:    lane_in.acc = a + b;
         ACT_SUB:    lane_in.acc = a - b;
         ACT_SHL:    lane_in.acc = (shift_amount[7]) ? '0 : (a << shift_amount[6:0]);
         ACT_SHR:    lane_in.acc = (shift_amount[7]) ? '0 : (a >> shift_amount[6:0]);
         ACT_SETBIT: lane_in.acc = a | onehot;
         ACT_GETBIT: lane_in.bit_value = a[bit_index];
         ACT_DIVMOD: lane_in.divide_by_zero = (b == '0);
         default:    lane_in.acc = '0;
      endcase
      valid_in = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
      if (advance) begin
         lane_ff <= lane_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_lane  = lane_ff;

endmodule

// ===== sv/u128alu_cell.sv =====
module u128alu_cell
   import u128alu_pkg::*;
#(
   parameter int unsigned BitPos = 127
)
(
   input  logic     clock,
   input  logic     reset,
   input  logic     advance,
   input  logic     in_valid,
   input  lane_type in_lane,
   output logic     out_valid,
   output lane_type out_lane
);

   logic     valid_ff;
   lane_type lane_ff, lane_in;
   logic [128:0] shifted;
   logic [128:0] diff;
   logic [127:0] part;

   always_comb begin
      lane_in = in_lane;
      shifted = {in_lane.rem, in_lane.a[BitPos]};
      diff    = shifted - {1'b0, in_lane.b};
      part    = in_lane.a << BitPos;
      if (in_lane.action == ACT_DIVMOD && !in_lane.divide_by_zero) begin
         // Restoring step: keep the shifted remainder when the subtract borrows.
         if (!diff[128]) begin
            lane_in.rem         = diff[127:0];
            lane_in.acc[BitPos] = 1'b1;
         end else begin
            lane_in.rem = shifted[127:0];
         end
      end else if (in_lane.action == ACT_MUL) begin
         // Shift-and-add: one multiplier bit per cell, summed into rem.
         lane_in.acc = '0;
         lane_in.rem = in_lane.rem + (in_lane.b[BitPos] ? part : '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         lane_ff <= lane_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_lane  = lane_ff;

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import u128alu_pkg::*;

   typedef struct packed {
      action_type   action;
      logic [127:0] a;
      logic [127:0] b;
      logic [7:0]   shift_amount;
      logic [6:0]   bit_index;
   } alu_req_type;

   typedef struct packed {
      logic [127:0] result;
      logic [127:0] remainder;
      logic         less_than;
      logic         equal;
      logic         bit_value;
      logic         divide_by_zero;
   } alu_rsp_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [279:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [263:0] rsp_tdata;

   alu_req_type pending_reqs[$];
   alu_rsp_type expected_rsps[$];
   int       mismatches = 0;
   int       cycle_count = 0;
   int       burst_left = 0;
   int       gap_left = 0;
   bit       stimulus_done = 1'b0;

   uint128_alu_with_divide_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [279:0] pack_req(alu_req_type r);
      return {6'd0, r.bit_index, r.shift_amount, r.b[63:0], r.b[127:64],
              r.a[63:0], r.a[127:64], r.action};
   endfunction

   // Expected response for every action; divmod uses bit-serial restoring division with a 129-bit partial remainder.
   function automatic alu_rsp_type compute_alu(alu_req_type r);
      alu_rsp_type  o;
      logic [128:0] part;
      logic [127:0] quo;
      o = '0;
      o.less_than = r.a < r.b;
      o.equal = r.a == r.b;
      case (r.action)
         ACT_ADD: o.result = r.a + r.b;
         ACT_SUB: o.result = r.a - r.b;
         ACT_MUL: o.result = r.a * r.b;
         ACT_SHL: o.result = (r.shift_amount >= 8'd128) ? '0 : r.a << r.shift_amount;
         ACT_SHR: o.result = (r.shift_amount >= 8'd128) ? '0 : r.a >> r.shift_amount;
         ACT_DIVMOD: begin
            if (r.b == '0) begin
               o.divide_by_zero = 1'b1;
            end else begin
               part = '0;
               quo = '0;
               for (int i = 127; i >= 0; i--) begin
                  part = {part[127:0], r.a[i]};
                  if (part >= {1'b0, r.b}) begin
                     part = part - {1'b0, r.b};
                     quo[i] = 1'b1;
                  end
               end
               o.result = quo;
               o.remainder = part[127:0];
            end
         end
         ACT_SETBIT: begin
            o.result = r.a;
            o.result[r.bit_index] = 1'b1;
         end
         default: o.bit_value = r.a[r.bit_index];
      endcase
      return o;
   endfunction

   function automatic logic [127:0] rand_operand();
      logic [127:0] v;
      v = {$urandom, $urandom, $urandom, $urandom};
      case ($urandom_range(0, 9))
         0: v = '0;
         1: v = '1;
         2: v = 128'd1 << $urandom_range(0, 127);
         3: v = v >> $urandom_range(0, 127);
         4: v = {1'b1, 127'd0};
         default: ;
      endcase
      return v;
   endfunction

   task automatic add_req(action_type act, logic [127:0] a, logic [127:0] b,
                          logic [7:0] sh, logic [6:0] bi);
      alu_req_type r;
      r.action = act;
      r.a = a;
      r.b = b;
      r.shift_amount = sh;
      r.bit_index = bi;
      pending_reqs.insert(pending_reqs.size(), r);
   endtask

   // Driver: bursts of words separated by random gaps.
   always @(posedge clock) begin
      if (!reset) begin
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_tvalid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               req_tdata <= pack_req(pending_reqs[0]);
               expected_rsps.insert(expected_rsps.size(),
                                    compute_alu(pending_reqs.pop_front()));
               req_tvalid <= 1'b1;
               if (burst_left > 0) begin
                  burst_left <= burst_left - 1;
               end else begin
                  burst_left <= $urandom_range(0, 30);
                  gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver stall pattern: long ready stretches mixed with stall runs.
   always @(posedge clock) begin
      if (!reset) begin
         case (cycle_count[9:8])
            2'd0: rsp_tready <= 1'b1;
            2'd1: rsp_tready <= ($urandom_range(0, 3) != 0);
            2'd2: rsp_tready <= ($urandom_range(0, 1) != 0);
            default: rsp_tready <= ($urandom_range(0, 9) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      alu_rsp_type got;
      alu_rsp_type want;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.result = {rsp_tdata[63:0], rsp_tdata[127:64]};
         got.remainder = {rsp_tdata[191:128], rsp_tdata[255:192]};
         got.less_than = rsp_tdata[256];
         got.equal = rsp_tdata[257];
         got.bit_value = rsp_tdata[258];
         got.divide_by_zero = rsp_tdata[259];
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected word: %h", got);
         end else begin
            want = expected_rsps.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Mismatch: expected %h, got %h", want, got);
            end
         end
      end
      if (cycle_count > 400000) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      logic [127:0] a;
      logic [127:0] b;
      int           act;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      // Directed words: extremes, every action and the corner cases.
      add_req(ACT_ADD, '1, 128'd1, 8'd0, 7'd0);
      add_req(ACT_SUB, '0, 128'd1, 8'd0, 7'd0);
      add_req(ACT_MUL, '1, '1, 8'd0, 7'd0);
      add_req(ACT_MUL, {64'd0, 64'hFFFFFFFFFFFFFFFF}, {64'd0, 64'hFFFFFFFFFFFFFFFF}, 8'd0, 7'd0);
      add_req(ACT_SHL, '1, '0, 8'd0, 7'd0);
      add_req(ACT_SHL, '1, '0, 8'd127, 7'd0);
      add_req(ACT_SHL, '1, '0, 8'd128, 7'd0);
      add_req(ACT_SHL, '1, '0, 8'd64, 7'd0);
      add_req(ACT_SHR, '1, '0, 8'd255, 7'd0);
      add_req(ACT_SHR, '1, '0, 8'd63, 7'd0);
      add_req(ACT_SHR, '1, '0, 8'd1, 7'd0);
      add_req(ACT_DIVMOD, '1, '0, 8'd0, 7'd0);
      add_req(ACT_DIVMOD, '1, '1, 8'd0, 7'd0);
      add_req(ACT_DIVMOD, '1, {1'b1, 127'd0}, 8'd0, 7'd0);
      add_req(ACT_DIVMOD, '1, {2'b11, 126'd5}, 8'd0, 7'd0);
      add_req(ACT_DIVMOD, 128'd7, 128'd9, 8'd0, 7'd0);
      add_req(ACT_DIVMOD, '1, 128'd3, 8'd0, 7'd0);
      add_req(ACT_SETBIT, '0, '0, 8'd0, 7'd127);
      add_req(ACT_SETBIT, '0, '1, 8'd0, 7'd0);
      add_req(ACT_GETBIT, '1, '0, 8'd0, 7'd127);
      add_req(ACT_GETBIT, 128'd1, '0, 8'd0, 7'd0);
      add_req(ACT_GETBIT, {64'd1, 64'd0}, {64'd1, 64'd0}, 8'd0, 7'd64);
      for (int i = 0; i < 1200; i++) begin
         a = rand_operand();
         b = ($urandom_range(0, 7) == 0) ? a : rand_operand();
         act = $urandom_range(0, 9);
         if (act > 7) act = ACT_DIVMOD;
         add_req(action_type'(act), a, b, 8'($urandom), 7'($urandom));
      end
      wait (pending_reqs.size() == 0);
      @(posedge clock);
      while (req_tvalid && !req_tready) @(posedge clock);
      wait (expected_rsps.size() == 0);
      repeat (200) @(posedge clock);
      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
